// File: design/rectangle_draw_engine_macros.svh
// Assertion macros for the rectangle draw engine.
// Both expect aclk and aresetn in scope.
`ifndef RECTANGLE_DRAW_ENGINE_MACROS_SVH
`define RECTANGLE_DRAW_ENGINE_MACROS_SVH

// Same-cycle implication
`define RDE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RDE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rde_pkg.sv
package rde_pkg;

    // Frame buffer geometry
    localparam int FB_WIDTH   = 256;
    localparam int FB_HEIGHT  = 256;
    localparam int PIXEL_BITS = 8;
    localparam int FB_DEPTH   = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W     = $clog2(FB_DEPTH);
    localparam int XW         = $clog2(FB_WIDTH);
    localparam int YW         = $clog2(FB_HEIGHT);

    // Item field widths
    localparam int CMD_W   = 2;
    localparam int CRN_W   = 8;
    localparam int SIZE_W  = 10;
    localparam int COLOR_W = 8;
    localparam int RV_W    = 8;
    // signed span of corner + size - 1
    localparam int CRD_W   = 11;

    // Microprogram step counter
    localparam int STEP_W = 4;

    // Step addresses
    localparam logic [STEP_W-1:0] ST_CLR_INIT = 4'd0;
    localparam logic [STEP_W-1:0] ST_CLR_LOOP = 4'd1;
    localparam logic [STEP_W-1:0] ST_DRAIN    = 4'd2;
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd3;
    localparam logic [STEP_W-1:0] ST_SORT     = 4'd4;
    localparam logic [STEP_W-1:0] ST_DRAW     = 4'd5;
    localparam logic [STEP_W-1:0] ST_RESULT   = 4'd6;
    localparam logic [STEP_W-1:0] ST_BACK     = 4'd7;
    localparam logic [STEP_W-1:0] ST_READ     = 4'd8;
    localparam logic [STEP_W-1:0] ST_CAPT     = 4'd9;

    typedef enum logic [CMD_W-1:0] {
        OP_OUTLINE = 2'd0,
        OP_FILL    = 2'd1,
        OP_XFILL   = 2'd2,
        OP_READ    = 2'd3
    } cmd_t;

    // Datapath actions
    typedef enum logic [2:0] {
        A_NOP,
        A_CLRINIT,
        A_SORT,
        A_PIXEL,
        A_READ,
        A_CAPT
    } act_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_MORE,
        C_IS_READ,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              take;
        logic              emit;
    } ctrl_t;

    typedef struct packed {
        logic last;
        logic is_read;
        logic wr_pend;
    } stat_t;

    // Control store
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{act: A_NOP, cond: C_ALWAYS, target: ST_IDLE, take: 1'b0, emit: 1'b0};
        case (step)
            ST_CLR_INIT: w = '{A_CLRINIT, C_NEVER,    ST_CLR_INIT, 1'b0, 1'b0};
            ST_CLR_LOOP: w = '{A_PIXEL,   C_MORE,     ST_CLR_LOOP, 1'b0, 1'b0};
            ST_DRAIN:    w = '{A_NOP,     C_NEVER,    ST_DRAIN,    1'b0, 1'b0};
            ST_IDLE:     w = '{A_NOP,     C_NO_ITEM,  ST_IDLE,     1'b1, 1'b0};
            ST_SORT:     w = '{A_SORT,    C_IS_READ,  ST_READ,     1'b0, 1'b0};
            ST_DRAW:     w = '{A_PIXEL,   C_MORE,     ST_DRAW,     1'b0, 1'b0};
            ST_RESULT:   w = '{A_NOP,     C_OUT_BUSY, ST_RESULT,   1'b0, 1'b1};
            ST_BACK:     w = '{A_NOP,     C_ALWAYS,   ST_IDLE,     1'b0, 1'b0};
            ST_READ:     w = '{A_READ,    C_NEVER,    ST_READ,     1'b0, 1'b0};
            ST_CAPT:     w = '{A_CAPT,    C_ALWAYS,   ST_RESULT,   1'b0, 1'b0};
            default:     w = '{A_NOP,     C_ALWAYS,   ST_IDLE,     1'b0, 1'b0};
        endcase
        return w;
    endfunction

endpackage

// File: design/rde_seq.sv
module rde_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_valid,
    input  logic            out_free,
    input  rde_pkg::stat_t  stat,
    output rde_pkg::ctrl_t  ctrl
);

    logic [rde_pkg::STEP_W-1:0] step_reg;
    logic [rde_pkg::STEP_W-1:0] step_next;
    logic                       jump;

    // control word of the current step
    assign ctrl = rde_pkg::ucode(step_reg);

    // condition select
    always_comb begin
        case (ctrl.cond)
            rde_pkg::C_NEVER:    jump = 1'b0;
            rde_pkg::C_ALWAYS:   jump = 1'b1;
            rde_pkg::C_NO_ITEM:  jump = !item_valid;
            rde_pkg::C_MORE:     jump = !stat.last;
            rde_pkg::C_IS_READ:  jump = stat.is_read;
            rde_pkg::C_OUT_BUSY: jump = !out_free;
            default:             jump = 1'b1;
        endcase
    end

    assign step_next = jump ? ctrl.target : step_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= rde_pkg::ST_CLR_INIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// File: design/rde_datapath.sv
module rde_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rde_pkg::ctrl_t                    ctrl,
    input  logic                              take,
    input  logic [rde_pkg::CMD_W-1:0]         cmd,
    input  logic [rde_pkg::CRN_W-1:0]         corner_x,
    input  logic [rde_pkg::CRN_W-1:0]         corner_y,
    input  logic signed [rde_pkg::SIZE_W-1:0] size_w,
    input  logic signed [rde_pkg::SIZE_W-1:0] size_h,
    input  logic [rde_pkg::COLOR_W-1:0]       color,
    output rde_pkg::stat_t                    stat,
    output logic [rde_pkg::RV_W-1:0]          read_value,
    output logic                              clipped
);

    localparam int CW = rde_pkg::CRD_W;
    localparam int XW = rde_pkg::XW;
    localparam int YW = rde_pkg::YW;
    localparam int AW = rde_pkg::ADDR_W;
    localparam int PW = rde_pkg::PIXEL_BITS;

    // command registers
    rde_pkg::cmd_t                    op_reg;
    logic [rde_pkg::CRN_W-1:0]        cx_reg, cy_reg;
    logic signed [rde_pkg::SIZE_W-1:0] w_reg, h_reg;
    logic [PW-1:0]                    color_reg;

    // ordered corners and clamped walk bounds
    logic signed [CW-1:0] x1_reg, x2_reg, y1_reg, y2_reg;
    logic [XW-1:0]        lx_reg, hx_reg, x_reg;
    logic [YW-1:0]        ly_reg, hy_reg, y_reg;
    logic                 clip_reg;
    logic [rde_pkg::RV_W-1:0] rv_reg;

    // write pipe
    logic                 wr_pend_reg;
    logic [AW-1:0]        wr_addr_reg;
    logic [PW-1:0]        rdata_reg;

    logic [PW-1:0]        mem [rde_pkg::FB_DEPTH];

    // sort logic
    logic signed [CW-1:0] cxs, cys, farx, fary, x1n, x2n, y1n, y2n;
    logic                 clipn;
    logic [XW-1:0]        lxn, hxn;
    logic [YW-1:0]        lyn, hyn;

    // pixel walk
    logic signed [CW-1:0] xs, ys;
    logic                 full_row, pix_en, row_end, last;
    logic [XW-1:0]        x_next;
    logic [YW-1:0]        y_next;
    logic [AW-1:0]        pix_addr, rd_addr, crn_addr;
    logic                 crn_in;
    logic [PW-1:0]        wdata;

    always_comb begin
        cxs  = $signed(CW'(cx_reg));
        cys  = $signed(CW'(cy_reg));
        farx = cxs + CW'(w_reg) - CW'(1);
        fary = cys + CW'(h_reg) - CW'(1);
        x1n  = (farx < cxs) ? farx : cxs;
        x2n  = (farx < cxs) ? cxs : farx;
        y1n  = (fary < cys) ? fary : cys;
        y2n  = (fary < cys) ? cys : fary;
        clipn = (x1n < 0) || (y1n < 0) ||
                (x2n >= $signed(CW'(rde_pkg::FB_WIDTH))) ||
                (y2n >= $signed(CW'(rde_pkg::FB_HEIGHT)));
        lxn = (x1n < 0) ? '0 : XW'(x1n);
        lyn = (y1n < 0) ? '0 : YW'(y1n);
        hxn = (x2n >= $signed(CW'(rde_pkg::FB_WIDTH)))  ? XW'(rde_pkg::FB_WIDTH - 1)  : XW'(x2n);
        hyn = (y2n >= $signed(CW'(rde_pkg::FB_HEIGHT))) ? YW'(rde_pkg::FB_HEIGHT - 1) : YW'(y2n);
    end

    // interior outline rows visit only the two ends of the span
    always_comb begin
        xs       = $signed(CW'(x_reg));
        ys       = $signed(CW'(y_reg));
        full_row = (op_reg != rde_pkg::OP_OUTLINE) || (ys == y1_reg) || (ys == y2_reg);
        pix_en   = full_row || (xs == x1_reg) || (xs == x2_reg);
        row_end  = (x_reg == hx_reg);
        last     = row_end && (y_reg == hy_reg);
        x_next   = row_end ? lx_reg : (full_row ? x_reg + 1'b1 : hx_reg);
        y_next   = row_end ? y_reg + 1'b1 : y_reg;
        pix_addr = AW'(AW'(y_reg) * AW'(rde_pkg::FB_WIDTH) + AW'(x_reg));
        crn_addr = AW'(AW'(cy_reg) * AW'(rde_pkg::FB_WIDTH) + AW'(cx_reg));
        crn_in   = (32'(cx_reg) < rde_pkg::FB_WIDTH) && (32'(cy_reg) < rde_pkg::FB_HEIGHT);
        rd_addr  = (ctrl.act == rde_pkg::A_READ) ? crn_addr : pix_addr;
        wdata    = (op_reg == rde_pkg::OP_FILL) ? color_reg : (rdata_reg ^ color_reg);
    end

    // frame buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            mem[wr_addr_reg] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // write pipe control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= (ctrl.act == rde_pkg::A_PIXEL) && pix_en;
        end
    end

    // command capture and walk registers
    always_ff @(posedge aclk) begin
        wr_addr_reg <= pix_addr;
        if (take) begin
            op_reg    <= rde_pkg::cmd_t'(cmd);
            cx_reg    <= corner_x;
            cy_reg    <= corner_y;
            w_reg     <= size_w;
            h_reg     <= size_h;
            color_reg <= PW'(color);
        end
        case (ctrl.act)
            rde_pkg::A_CLRINIT: begin
                op_reg    <= rde_pkg::OP_FILL;
                color_reg <= '0;
                lx_reg    <= '0;
                ly_reg    <= '0;
                hx_reg    <= XW'(rde_pkg::FB_WIDTH - 1);
                hy_reg    <= YW'(rde_pkg::FB_HEIGHT - 1);
                x_reg     <= '0;
                y_reg     <= '0;
            end
            rde_pkg::A_SORT: begin
                x1_reg   <= x1n;
                x2_reg   <= x2n;
                y1_reg   <= y1n;
                y2_reg   <= y2n;
                lx_reg   <= lxn;
                hx_reg   <= hxn;
                ly_reg   <= lyn;
                hy_reg   <= hyn;
                x_reg    <= lxn;
                y_reg    <= lyn;
                clip_reg <= clipn;
                rv_reg   <= '0;
            end
            rde_pkg::A_PIXEL: begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
            rde_pkg::A_READ: begin
                clip_reg <= !crn_in;
            end
            rde_pkg::A_CAPT: begin
                rv_reg <= crn_in ? rde_pkg::RV_W'(rdata_reg) : '0;
            end
            default: begin
            end
        endcase
    end

    assign stat.last    = last;
    assign stat.is_read = (op_reg == rde_pkg::OP_READ);
    assign stat.wr_pend = wr_pend_reg;
    assign read_value   = rv_reg;
    assign clipped      = clip_reg;

endmodule

// File: design/rectangle_draw_engine.sv
// Channel   Dir  Handshake          Payload
// s_ item   in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: corner, size, color
// m_ item   out  m_tvalid/m_tready  m_tdata: read_value, clipped
//
// Steps: a draw goes idle (take), sort, a step per visited pixel, result, back;
// a read goes idle, sort, read, capture, result, back. A fill visits every
// in-buffer pixel; an outline the in-buffer top and bottom rows and two pixels
// on each other row (one for a single column). One read-modify-write per cycle
// sets the pixel rate. Reset: a sweep clears the buffer with s_tready low.
// A waiting m_ result holds only the next item's result step.
`include "rectangle_draw_engine_macros.svh"

module rectangle_draw_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] corner_x, [15:8] corner_y, [25:16] size_w, [35:26] size_h,
    // [43:36] color, [47:44] zero
    input  logic [47:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_value, [8] clipped, [15:9] zero
    output logic [15:0] m_tdata
);

    rde_pkg::ctrl_t ctrl;
    rde_pkg::stat_t stat;
    logic           accept;
    logic           out_free;
    logic           out_load;
    logic [rde_pkg::RV_W-1:0] rv;
    logic           clip;

    logic           m_tvalid_reg, m_tvalid_next;
    logic [15:0]    m_tdata_reg;

    assign s_tready = ctrl.take;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = ctrl.emit && out_free;

    rde_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .out_free   (out_free),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    rde_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .take       (accept),
        .cmd        (s_tuser),
        .corner_x   (s_tdata[7:0]),
        .corner_y   (s_tdata[15:8]),
        .size_w     (s_tdata[25:16]),
        .size_h     (s_tdata[35:26]),
        .color      (s_tdata[43:36]),
        .stat       (stat),
        .read_value (rv),
        .clipped    (clip)
    );

    // output register
    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {7'b0, clip, rv};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `RDE_ASSERT_NXT(a_busy_after_take, accept, !s_tready, "item taken while busy")
    `RDE_ASSERT_IMP(a_idle_no_write, s_tready, !stat.wr_pend, "write pending at idle")
    `RDE_ASSERT_IMP(a_draw_rv_zero, out_load && !stat.is_read, rv == '0, "draw item has a value")

endmodule

// File: bench/rectangle_draw_engine_test.sv
`timescale 1ns / 100ps

module rectangle_draw_engine_test;

    // Longest quiet spell is the reset sweep or one full-buffer fill
    localparam int STALL_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [7:0] value;
        logic       clipped;
    } pixel_reply_t;

    typedef struct packed {
        rde_pkg::cmd_t op;
        logic [7:0]    cx;
        logic [7:0]    cy;
        logic [9:0]    w;
        logic [9:0]    h;
        logic [7:0]    color;
        logic          known;
        logic [7:0]    value;
        logic          clipped;
    } shape_row_t;

    // Opening items; rows with known set carry a reply that can be read off by eye
    localparam shape_row_t OPENING_ROWS [26] = '{
        '{rde_pkg::OP_READ,    8'd0,   8'd0,   10'h000, 10'h000, 8'h00, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd255, 8'd255, 10'h000, 10'h000, 8'h00, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_FILL,    8'd10,  8'd10,  10'h004, 10'h003, 8'hAB, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd10,  8'd10,  10'h000, 10'h000, 8'h00, 1'b1, 8'hAB, 1'b0},
        '{rde_pkg::OP_READ,    8'd13,  8'd12,  10'h000, 10'h000, 8'h00, 1'b1, 8'hAB, 1'b0},
        '{rde_pkg::OP_READ,    8'd14,  8'd12,  10'h000, 10'h000, 8'h00, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_XFILL,   8'd11,  8'd11,  10'h002, 10'h002, 8'hFF, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd11,  8'd11,  10'h000, 10'h000, 8'h00, 1'b1, 8'h54, 1'b0},
        '{rde_pkg::OP_OUTLINE, 8'd20,  8'd20,  10'h005, 10'h004, 8'h0F, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd20,  8'd20,  10'h000, 10'h000, 8'h00, 1'b1, 8'h0F, 1'b0},
        '{rde_pkg::OP_READ,    8'd22,  8'd21,  10'h000, 10'h000, 8'h00, 1'b1, 8'h00, 1'b0},
        // outline one row thick, then one column thick
        '{rde_pkg::OP_OUTLINE, 8'd30,  8'd5,   10'h006, 10'h001, 8'h33, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd32,  8'd5,   10'h000, 10'h000, 8'h00, 1'b1, 8'h33, 1'b0},
        '{rde_pkg::OP_OUTLINE, 8'd40,  8'd5,   10'h001, 10'h005, 8'h11, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd40,  8'd7,   10'h000, 10'h000, 8'h00, 1'b1, 8'h11, 1'b0},
        // zero size spans corner-1 .. corner
        '{rde_pkg::OP_FILL,    8'd50,  8'd50,  10'h000, 10'h000, 8'h77, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd49,  8'd49,  10'h000, 10'h000, 8'h00, 1'b1, 8'h77, 1'b0},
        '{rde_pkg::OP_FILL,    8'd0,   8'd0,   10'h000, 10'h000, 8'h01, 1'b1, 8'h00, 1'b1},
        // negative sizes
        '{rde_pkg::OP_XFILL,   8'd100, 8'd100, 10'h3FD, 10'h3FE, 8'h80, 1'b0, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd96,  8'd99,  10'h000, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0},
        // size extremes +511 / -512, then a negative width past the left edge
        '{rde_pkg::OP_OUTLINE, 8'd255, 8'd255, 10'h1FF, 10'h200, 8'hC3, 1'b1, 8'h00, 1'b1},
        '{rde_pkg::OP_OUTLINE, 8'd7,   8'd3,   10'h3F7, 10'h007, 8'h5A, 1'b0, 8'h00, 1'b0},
        // whole buffer filled, then toggled back to zero
        '{rde_pkg::OP_FILL,    8'd0,   8'd0,   10'h100, 10'h100, 8'hFF, 1'b1, 8'h00, 1'b0},
        '{rde_pkg::OP_READ,    8'd128, 8'd128, 10'h000, 10'h000, 8'h00, 1'b1, 8'hFF, 1'b0},
        '{rde_pkg::OP_XFILL,   8'd255, 8'd0,   10'h200, 10'h1FF, 8'hFF, 1'b1, 8'h00, 1'b1},
        '{rde_pkg::OP_READ,    8'd0,   8'd255, 10'h000, 10'h000, 8'h00, 1'b1, 8'h00, 1'b0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [7:0] corner_x, [15:8] corner_y, [25:16] size_w, [35:26] size_h,
    // [43:36] color, [47:44] zero
    logic [47:0] s_tdata = '0;
    // [1:0] cmd
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] read_value, [8] clipped, [15:9] zero
    logic [15:0] m_tdata;

    bit [7:0]     shadow_fb [rde_pkg::FB_WIDTH*rde_pkg::FB_HEIGHT];
    pixel_reply_t pending_replies [$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           long_hold_req = 1'b0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    logic [7:0]   last_cx = '0;
    logic [7:0]   last_cy = '0;

    rectangle_draw_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // One pixel of the shadow buffer: plain write for fill, XOR otherwise
    function automatic void put_pixel(input int x, input int y, input rde_pkg::cmd_t op,
                                      input logic [7:0] color);
        int a;
        a = y * rde_pkg::FB_WIDTH + x;
        if (op == rde_pkg::OP_FILL) begin
            shadow_fb[a] = color;
        end else begin
            shadow_fb[a] = shadow_fb[a] ^ color;
        end
    endfunction

    // Applies one command to the shadow buffer and returns the reply it owes
    function automatic pixel_reply_t rasterise(input rde_pkg::cmd_t op, input logic [7:0] cx,
                                               input logic [7:0] cy, input logic [9:0] w_raw,
                                               input logic [9:0] h_raw, input logic [7:0] color);
        pixel_reply_t rep;
        int x1, y1, x2, y2, swap, lx, hx, ly, hy;
        rep = '0;
        if (op == rde_pkg::OP_READ) begin
            if (int'(cx) < rde_pkg::FB_WIDTH && int'(cy) < rde_pkg::FB_HEIGHT) begin
                rep.value = shadow_fb[int'(cy) * rde_pkg::FB_WIDTH + int'(cx)];
            end else begin
                rep.clipped = 1'b1;
            end
            return rep;
        end
        x1 = int'(cx);
        y1 = int'(cy);
        x2 = int'(cx) + int'($signed(w_raw)) - 1;
        y2 = int'(cy) + int'($signed(h_raw)) - 1;
        if (x1 > x2) begin
            swap = x1; x1 = x2; x2 = swap;
        end
        if (y1 > y2) begin
            swap = y1; y1 = y2; y2 = swap;
        end
        rep.clipped = (x1 < 0 || y1 < 0 || x2 >= rde_pkg::FB_WIDTH ||
                       y2 >= rde_pkg::FB_HEIGHT);
        lx = (x1 < 0) ? 0 : x1;
        ly = (y1 < 0) ? 0 : y1;
        hx = (x2 > rde_pkg::FB_WIDTH - 1) ? rde_pkg::FB_WIDTH - 1 : x2;
        hy = (y2 > rde_pkg::FB_HEIGHT - 1) ? rde_pkg::FB_HEIGHT - 1 : y2;
        // outline: full top and bottom rows, side columns only on inner rows
        for (int y = ly; y <= hy; y++) begin
            if (op != rde_pkg::OP_OUTLINE || y == y1 || y == y2) begin
                for (int x = lx; x <= hx; x++) put_pixel(x, y, op, color);
            end else begin
                if (x1 >= 0 && x1 < rde_pkg::FB_WIDTH) put_pixel(x1, y, op, color);
                if (x2 != x1 && x2 >= 0 && x2 < rde_pkg::FB_WIDTH) put_pixel(x2, y, op, color);
            end
        end
        return rep;
    endfunction

    // Mostly small sizes, some medium, a rare one from the full 10-bit range
    function automatic logic [9:0] pick_size();
        int roll;
        roll = $urandom_range(0, 199);
        if (roll < 2) begin
            return 10'($urandom_range(0, 1023));
        end else if (roll < 20) begin
            return 10'($urandom_range(0, 80) - 40);
        end else begin
            return 10'($urandom_range(0, 16) - 8);
        end
    endfunction

    // Offers one item, waits for it to be taken, then logs the reply it owes
    task automatic offer_cmd(input rde_pkg::cmd_t op, input logic [7:0] cx,
                             input logic [7:0] cy,
                             input logic [9:0] w, input logic [9:0] h,
                             input logic [7:0] color, input bit known,
                             input pixel_reply_t known_reply);
        pixel_reply_t pred;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, color, h, w, cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = rasterise(op, cx, cy, w, h, color);
        pending_replies.push_back(known ? known_reply : pred);
        if (op != rde_pkg::OP_READ) begin
            last_cx = cx;
            last_cy = cy;
        end
    endtask

    // Random commands; most reads land near the last drawn corner
    task automatic random_cmds(input int count);
        rde_pkg::cmd_t op;
        logic [7:0]    cx, cy, color;
        logic [9:0]    w, h;
        for (int i = 0; i < count; i++) begin
            op    = rde_pkg::cmd_t'($urandom_range(0, 3));
            color = 8'($urandom_range(0, 255));
            if (op == rde_pkg::OP_READ && $urandom_range(0, 9) < 7) begin
                cx = last_cx + 8'($urandom_range(0, 8)) - 8'd4;
                cy = last_cy + 8'($urandom_range(0, 8)) - 8'd4;
            end else begin
                cx = 8'($urandom_range(0, 255));
                cy = 8'($urandom_range(0, 255));
            end
            w = pick_size();
            h = pick_size();
            offer_cmd(op, cx, cy, w, h, color, 1'b0, '0);
        end
    endtask

    // Reply side: random stalls plus one long hold-off on request
    initial begin
        int  hold_left;
        bit  hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !hold_served) begin
                hold_left   = LONG_HOLD;
                hold_served = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Reply checker and quiet-cycle count
    always @(posedge aclk) begin
        pixel_reply_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: reply with none outstanding: value %h clipped %b",
                             $realtime, m_tdata[7:0], m_tdata[8]);
                end
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[7:0] !== want.value || m_tdata[8] !== want.clipped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: reply mismatch: value %h/%h clipped %b/%b (exp/got)",
                                 $realtime, want.value, m_tdata[7:0], want.clipped,
                                 m_tdata[8]);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (OPENING_ROWS[i]) begin
            offer_cmd(OPENING_ROWS[i].op, OPENING_ROWS[i].cx, OPENING_ROWS[i].cy,
                      OPENING_ROWS[i].w, OPENING_ROWS[i].h, OPENING_ROWS[i].color,
                      OPENING_ROWS[i].known,
                      pixel_reply_t'{OPENING_ROWS[i].value, OPENING_ROWS[i].clipped});
        end

        random_cmds(300);
        send_idle_pct = 57;
        random_cmds(300);
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        random_cmds(300);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        random_cmds(300);

        // reply side held off while items keep coming, so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b1;
        random_cmds(60);

        // sender rests until every reply is back
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
        random_cmds(270);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
